// File: rtl/core/actr_pkg.sv
// ----------------------------------------------------------------------------
// actr_pkg: shared types and AES helpers
// S-box, round constants, round and key-schedule functions, queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none
package actr_pkg;

  localparam int BlockBytes = 16;
  localparam int Rounds     = 10;
  localparam int RndW       = 4;
  localparam int QDepth     = 2;

  localparam logic [0:0] CfgKeyUpper = 1'b0;
  localparam logic [0:0] CfgKeyLower = 1'b1;

  // Queue entry: one classified item handed from front to back
  typedef struct packed {
    logic [127:0] ctr;
    logic [127:0] data;
    logic [15:0]  mask;
    logic [4:0]   nbytes;
    logic         last;
  } job_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] r;
    unique case (x)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Byte i of a block sits in bits [127-8i -: 8]
  function automatic logic [7:0] byte_of(input logic [127:0] v, input int i);
    return v[127-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // One round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey
  function automatic logic [127:0] aes_round(input logic [127:0] s,
                                              input logic [127:0] rk,
                                              input logic mix);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i+4*c] = sbox(byte_of(s, i + 4*((c+i) & 3)));
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      o[127-8*i -: 8] = t[i];
    end
    return o ^ rk;
  endfunction

  // Next round key from the previous one
  function automatic logic [127:0] key_step(input logic [127:0] k,
                                             input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    {w0, w1, w2, w3} = k;
    t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [7:0] rc_next(input logic [7:0] rc);
    return xtime(rc);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/actr_front.sv
// ----------------------------------------------------------------------------
// actr_front: input stage
// Accepts blocks, binds each to the current counter, builds the byte mask
// and advances the counter, or clears it after a last block.
// ----------------------------------------------------------------------------
`default_nettype none
module actr_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [63:0]      in_cipher_upper,
  input  wire logic [63:0]      in_cipher_lower,
  input  wire logic [4:0]       in_valid_bytes,
  input  wire logic             in_last_block,
  output logic                  job_push,
  output actr_pkg::job_t        job_data,
  input  wire logic             job_full
);
  import actr_pkg::*;

  logic [63:0] ctr_top_r, ctr_top_nxt;
  logic [63:0] ctr_bot_r, ctr_bot_nxt;
  logic        acc;

  assign in_ready = !job_full;
  assign acc      = in_valid && in_ready;
  assign job_push = acc;

  // Build the byte mask: byte i kept when i < count
  always_comb begin
    job_data.ctr    = {ctr_top_r, ctr_bot_r};
    job_data.data   = {in_cipher_upper, in_cipher_lower};
    job_data.nbytes = in_valid_bytes;
    job_data.last   = in_last_block;
    for (int i = 0; i < 16; i++) begin
      job_data.mask[15-i] = (in_valid_bytes > 5'(i));
    end
  end

  // Advance counter, or clear it after a last block; byte 0 never takes a carry
  always_comb begin
    ctr_top_nxt = ctr_top_r;
    ctr_bot_nxt = ctr_bot_r;
    if (acc) begin
      if (in_last_block) begin
        ctr_top_nxt = '0;
        ctr_bot_nxt = '0;
      end else begin
        ctr_bot_nxt = ctr_bot_r + 64'd1;
        if (ctr_bot_r == '1) begin
          ctr_top_nxt = {ctr_top_r[63:56], ctr_top_r[55:0] + 56'd1};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_top_r <= '0;
      ctr_bot_r <= '0;
    end else begin
      ctr_top_r <= ctr_top_nxt;
      ctr_bot_r <= ctr_bot_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/actr_queue.sv
// ----------------------------------------------------------------------------
// actr_queue: two-entry job queue
// Decouples the input stage from the cipher engine.
// ----------------------------------------------------------------------------
`default_nettype none
module actr_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire actr_pkg::job_t push_data,
  output logic                full,
  input  wire logic           pop,
  output actr_pkg::job_t      pop_data,
  output logic                not_empty
);
  import actr_pkg::*;

  job_t       mem_r [QDepth];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'(QDepth));
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rp_r];

  // Advance pointers and count
  always_comb begin
    wp_nxt  = wp_r + 1'(push);
    rp_nxt  = rp_r + 1'(pop);
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/actr_engine.sv
// ----------------------------------------------------------------------------
// actr_engine: round-iterated AES-128 core and output register
// Runs one round per cycle, key schedule alongside, the last round held until
// the output register frees, then XORs the keystream into the masked block.
// ----------------------------------------------------------------------------
`default_nettype none
module actr_engine (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [127:0]   key,
  input  wire actr_pkg::job_t job,
  input  wire logic           job_avail,
  output logic                job_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [63:0]         out_plain_upper,
  output logic [63:0]         out_plain_lower,
  output logic [4:0]          out_valid_bytes,
  output logic                out_last
);
  import actr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t        state_r, state_nxt;
  logic [RndW-1:0] rnd_r, rnd_nxt;
  logic [127:0]  st_r, st_nxt;
  logic [127:0]  rk_r, rk_nxt;
  logic [7:0]    rc_r, rc_nxt;
  logic [127:0]  data_r;
  logic [15:0]   mask_r;
  logic [4:0]    nb_r;
  logic          last_r;
  logic          ov_r, ov_nxt;
  logic [127:0]  res_r, res_nxt;
  logic [4:0]    onb_r;
  logic          olast_r;
  logic [127:0]  rk_cur;
  logic [127:0]  ks;
  logic          done;
  logic          out_free;

  assign out_free = !ov_r || out_ready;
  assign job_pop  = (state_r == ST_IDLE) && job_avail;
  assign rk_cur   = key_step(rk_r, rc_r);
  assign ks       = aes_round(st_r, rk_cur, rnd_r != 4'(Rounds));
  assign done     = (state_r == ST_RUN) && (rnd_r == 4'(Rounds)) && out_free;

  // Sequence rounds; hold the last round until the output register frees
  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    st_nxt    = st_r;
    rk_nxt    = rk_r;
    rc_nxt    = rc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job_avail) begin
          state_nxt = ST_RUN;
          rnd_nxt   = 4'd1;
          st_nxt    = job.ctr ^ key;
          rk_nxt    = key;
          rc_nxt    = 8'h01;
        end
      end
      ST_RUN: begin
        if (rnd_r != 4'(Rounds)) begin
          rnd_nxt = rnd_r + 4'd1;
          st_nxt  = ks;
          rk_nxt  = rk_cur;
          rc_nxt  = rc_next(rc_r);
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    ov_nxt  = ov_r && !out_ready;
    res_nxt = res_r;
    if (done) begin
      ov_nxt = 1'b1;
      for (int i = 0; i < 16; i++) begin
        res_nxt[127-8*i -: 8] = mask_r[15-i] ?
          (data_r[127-8*i -: 8] ^ ks[127-8*i -: 8]) : 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rnd_r <= rnd_nxt;
    st_r  <= st_nxt;
    rk_r  <= rk_nxt;
    rc_r  <= rc_nxt;
    res_r <= res_nxt;
    if (job_pop) begin
      data_r <= job.data;
      mask_r <= job.mask;
      nb_r   <= job.nbytes;
      last_r <= job.last;
    end
    if (done) begin
      onb_r   <= nb_r;
      olast_r <= last_r;
    end
  end

  assign out_valid       = ov_r;
  assign out_plain_upper = res_r[127:64];
  assign out_plain_lower = res_r[63:0];
  assign out_valid_bytes = onb_r;
  assign out_last        = olast_r;

endmodule
`default_nettype wire

// File: rtl/core/aes128_ctr_keystream_xor.sv
// ----------------------------------------------------------------------------
// aes128_ctr_keystream_xor: AES-128 counter-mode block decryptor
// Top level joining input stage, job queue and cipher engine.
// ----------------------------------------------------------------------------
// Each transaction carries a 16-byte block; the result is the block XORed
// with AES-128 of the internal counter, bytes past the count given as zero.
// The counter advances per block over bytes 15..1 and clears after a last
// block. The round engine iterates one round per cycle but holds the last
// round while the output register is full; a block takes a load step and
// ten rounds, and no new block starts before the last is done. A two-entry
// queue in front and an output register behind let input and output stall
// independently. Key writes take effect for blocks started after the write.
`default_nettype none
module aes128_ctr_keystream_xor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_cipher_upper,
  input  wire logic [63:0] in_cipher_lower,
  input  wire logic [4:0]  in_valid_bytes,
  input  wire logic        in_last_block,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_plain_upper,
  output logic [63:0]      out_plain_lower,
  output logic [4:0]       out_valid_bytes,
  output logic             out_last
);
  import actr_pkg::*;

  logic [63:0] key_up_r, key_lo_r;
  logic        push, full, pop, avail;
  job_t        push_data, pop_data;

  // Key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_up_r <= '0;
      key_lo_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgKeyUpper: key_up_r <= cfg_data;
        CfgKeyLower: key_lo_r <= cfg_data;
        default: ;
      endcase
    end
  end

  actr_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cipher_upper, .in_cipher_lower,
    .in_valid_bytes, .in_last_block,
    .job_push(push), .job_data(push_data), .job_full(full)
  );

  actr_queue u_queue (
    .clk, .rst_n, .push, .push_data, .full,
    .pop, .pop_data, .not_empty(avail)
  );

  actr_engine u_engine (
    .clk, .rst_n, .key({key_up_r, key_lo_r}), .job(pop_data),
    .job_avail(avail), .job_pop(pop),
    .out_valid, .out_ready, .out_plain_upper, .out_plain_lower,
    .out_valid_bytes, .out_last
  );

endmodule
`default_nettype wire

// File: tb/tb_aes128_ctr_keystream_xor.sv
// ----------------------------------------------------------------------------
// tb_aes128_ctr_keystream_xor: self-checking testbench for the CTR decryptor
// Drives ciphertext blocks under several keys, predicts each plaintext with
// an independent AES-128 model and compares every result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_aes128_ctr_keystream_xor;
  import actr_pkg::*;

  localparam int ResetCycles = 7;
  localparam int DrainCycles = 40;
  localparam int CycleLimit  = 600000;
  localparam int RandomItems = 750;

  typedef struct {
    logic [63:0] upper;
    logic [63:0] lower;
    logic [4:0]  nbytes;
    logic        last;
  } plain_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_cipher_upper;
  logic [63:0] in_cipher_lower;
  logic [4:0]  in_valid_bytes;
  logic        in_last_block;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_plain_upper;
  logic [63:0] out_plain_lower;
  logic [4:0]  out_valid_bytes;
  logic        out_last;

  // Predictor state: key and counter as the block should hold them
  logic [127:0] model_key;
  logic [127:0] model_ctr;
  logic [7:0]   sub_tab [256];
  plain_t       plain_q [$];

  int errors;
  int sent_cnt;
  int checked_cnt;
  int key_cnt;
  int cycles;
  int burst_left;
  int stall_mode;

  aes128_ctr_keystream_xor u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cipher_upper (in_cipher_upper),
    .in_cipher_lower (in_cipher_lower),
    .in_valid_bytes  (in_valid_bytes),
    .in_last_block   (in_last_block),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_plain_upper (out_plain_upper),
    .out_plain_lower (out_plain_lower),
    .out_valid_bytes (out_valid_bytes),
    .out_last        (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $realtime, plain_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // GF(2^8) multiply modulo the AES polynomial
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p = p ^ x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // Build the substitution table from inverse plus affine map
  task automatic build_sub_table();
    logic [7:0] inv;
    logic [7:0] v;
    for (int n = 0; n < 256; n++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gf_mul(inv, n[7:0]);
      if (n == 0) inv = 8'h00;
      v = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
          ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sub_tab[n] = v;
    end
  endtask

  // Encrypt one block; byte i sits in bits 127-8i
  function automatic logic [127:0] aes_ref_block(input logic [127:0] key,
                                                 input logic [127:0] blk);
    logic [7:0]  st [16];
    logic [7:0]  sh [16];
    logic [7:0]  rk [16];
    logic [7:0]  tw [4];
    logic [7:0]  rc;
    logic [7:0]  a0, a1, a2, a3, sum;
    logic [127:0] res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127-8*i -: 8];
      st[i] = blk[127-8*i -: 8] ^ rk[i];
    end
    for (int r = 1; r <= 10; r++) begin
      // advance round key
      tw[0] = sub_tab[rk[13]] ^ rc;
      tw[1] = sub_tab[rk[14]];
      tw[2] = sub_tab[rk[15]];
      tw[3] = sub_tab[rk[12]];
      for (int i = 0; i < 16; i++) begin
        rk[i] = rk[i] ^ ((i < 4) ? tw[i] : rk[i-4]);
      end
      rc = gf_mul(rc, 8'h02);
      // substitute and shift rows
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++)
          sh[i+4*c] = sub_tab[st[i + 4*((c+i) % 4)]];
      // mix columns except in the last round
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = sh[4*c]; a1 = sh[4*c+1]; a2 = sh[4*c+2]; a3 = sh[4*c+3];
          sum = a0 ^ a1 ^ a2 ^ a3;
          sh[4*c]   = a0 ^ sum ^ gf_mul(a0 ^ a1, 8'h02);
          sh[4*c+1] = a1 ^ sum ^ gf_mul(a1 ^ a2, 8'h02);
          sh[4*c+2] = a2 ^ sum ^ gf_mul(a2 ^ a3, 8'h02);
          sh[4*c+3] = a3 ^ sum ^ gf_mul(a3 ^ a0, 8'h02);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = sh[i] ^ rk[i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  // Expected plaintext for one accepted block; advance the counter, or clear it after a last block
  task automatic predict_plain(input logic [63:0] cu, input logic [63:0] cl,
                               input logic [4:0] nb, input logic lst);
    logic [127:0] ks;
    logic [127:0] txt;
    plain_t       p;
    int           lim;
    ks  = aes_ref_block(model_key, model_ctr);
    txt = {cu, cl} ^ ks;
    lim = (nb > 16) ? 16 : nb;
    for (int i = 0; i < 16; i++) begin
      if (i >= lim) txt[127-8*i -: 8] = 8'h00;
    end
    p.upper  = txt[127:64];
    p.lower  = txt[63:0];
    p.nbytes = nb;
    p.last   = lst;
    plain_q = {plain_q, p};
    if (lst) begin
      model_ctr = '0;
    end else begin
      model_ctr[63:0] = model_ctr[63:0] + 64'd1;
      if (model_ctr[63:0] == 64'd0)
        model_ctr[119:64] = model_ctr[119:64] + 56'd1;
    end
  endtask

  // Send one block in bursts with random gaps between them
  task automatic send_block(input logic [63:0] cu, input logic [63:0] cl,
                            input logic [4:0] nb, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    in_valid        <= 1'b1;
    in_cipher_upper <= cu;
    in_cipher_lower <= cl;
    in_valid_bytes  <= nb;
    in_last_block   <= lst;
    do @(posedge clk); while (!in_ready);
    predict_plain(cu, cl, nb, lst);
    sent_cnt++;
    burst_left--;
    @(negedge clk);
  endtask

  // Lower valid and wait until every expected result has been checked
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (plain_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Write both key halves while the block is idle
  task automatic load_key(input logic [127:0] key);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CfgKeyUpper;
    cfg_data  <= key[127:64];
    @(negedge clk);
    cfg_index <= CfgKeyLower;
    cfg_data  <= key[63:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    model_key = key;
    key_cnt++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Receiver stall pattern: switch between free, random and heavy stalls
  always @(negedge clk) begin
    if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    plain_t e;
    if (rst_n && out_valid && out_ready) begin
      if (plain_q.size() == 0) begin
        $display("%0t unexpected result upper=%h lower=%h", $realtime,
                 out_plain_upper, out_plain_lower);
        errors++;
      end else begin
        e = plain_q.pop_front();
        checked_cnt++;
        if (out_plain_upper !== e.upper) begin
          $display("%0t plain_upper exp=%h act=%h", $realtime, e.upper, out_plain_upper);
          errors++;
        end
        if (out_plain_lower !== e.lower) begin
          $display("%0t plain_lower exp=%h act=%h", $realtime, e.lower, out_plain_lower);
          errors++;
        end
        if (out_valid_bytes !== e.nbytes) begin
          $display("%0t valid_bytes exp=%0d act=%0d", $realtime, e.nbytes,
                   out_valid_bytes);
          errors++;
        end
        if (out_last !== e.last) begin
          $display("%0t last exp=%b act=%b", $realtime, e.last, out_last);
          errors++;
        end
      end
    end
  end

  // Zero key after reset: extremes of data and byte counts 0, 1 and 16
  task automatic test_reset_key();
    send_block('0, '0, 5'd16, 1'b0);
    send_block('1, '1, 5'd16, 1'b0);
    send_block('1, '1, 5'd0, 1'b0);
    send_block('1, '1, 5'd1, 1'b1);
  endtask

  // Byte counts: zero, short, full, above sixteen, short not last
  task automatic test_byte_counts();
    logic [4:0] counts [10];
    counts = '{5'd0, 5'd1, 5'd7, 5'd8, 5'd9, 5'd15, 5'd16, 5'd17, 5'd24, 5'd31};
    foreach (counts[i]) send_block(rand64(), rand64(), counts[i], 1'b0);
    send_block('1, '1, 5'd3, 1'b1);
  endtask

  // Key extremes: all ones, then a single upper bit and a single lower bit
  task automatic test_key_extremes();
    load_key('1);
    send_block('1, '0, 5'd16, 1'b0);
    send_block('0, '1, 5'd16, 1'b1);
    load_key({1'b1, 127'd0});
    send_block(rand64(), rand64(), 5'd16, 1'b0);
    send_block(rand64(), rand64(), 5'd12, 1'b1);
    load_key({127'd0, 1'b1});
    send_block(rand64(), rand64(), 5'd16, 1'b1);
  endtask

  // Random messages: mostly well-formed, some noisy counts and early ends
  task automatic test_random_messages();
    int nblk;
    int done;
    logic [4:0] nb;
    logic lst;
    done = 0;
    while (done < RandomItems) begin
      if (done % 150 == 0) load_key({rand64(), rand64()});
      nblk = $urandom_range(1, 12);
      for (int b = 0; b < nblk; b++) begin
        lst = (b == nblk - 1);
        nb  = lst ? 5'($urandom_range(1, 16)) : 5'd16;
        if ($urandom_range(0, 9) == 0) begin
          nb  = 5'($urandom_range(0, 31));
          lst = 1'($urandom_range(0, 1));
        end
        send_block(rand64(), rand64(), nb, lst);
        done++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CfgKeyUpper;
    cfg_data = '0;
    in_valid = 1'b0;
    in_cipher_upper = '0;
    in_cipher_lower = '0;
    in_valid_bytes = '0;
    in_last_block = 1'b0;
    out_ready = 1'b0;
    errors = 0;
    sent_cnt = 0;
    checked_cnt = 0;
    key_cnt = 0;
    cycles = 0;
    burst_left = 0;
    stall_mode = 0;
    model_key = '0;
    model_ctr = '0;
    build_sub_table();
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_key();
    test_byte_counts();
    test_key_extremes();
    test_random_messages();
    drain();

    $display("Sent %0d blocks under %0d keys, checked %0d plaintext results",
             sent_cnt, key_cnt, checked_cnt);
    $display("Covered byte counts 0..31, multi-block messages and key extremes");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: aes128_ctr_keystream_xor.f
rtl/core/actr_pkg.sv
rtl/core/actr_front.sv
rtl/core/actr_queue.sv
rtl/core/actr_engine.sv
rtl/core/aes128_ctr_keystream_xor.sv
tb/tb_aes128_ctr_keystream_xor.sv
